// File: rtl/kap_pkg.sv
// Shared constants, types and the sort schedule of the Kaprekar routine core.
`timescale 1ns / 1ps
package kap_pkg;

  // Field widths
  localparam int unsigned ValueW = 14;
  localparam int unsigned StepW  = 6;
  localparam int unsigned DigitW = 4;
  localparam int unsigned QuotW  = 11;   // 16383 / 10 fits in 11 bits
  localparam int unsigned NDigits = 4;
  localparam int unsigned IdxW   = 2;
  localparam int unsigned CntW   = 3;

  // Stream widths (whole bytes)
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 24;

  // Constants of the routine
  localparam logic [ValueW-1:0] KapTarget   = 14'd6174;
  localparam logic [StepW-1:0]  LimitReset  = 6'd7;
  localparam logic [15:0]       Recip10     = 16'd52429;  // ceil(2^19 / 10)
  localparam int unsigned       RecipShift  = 19;
  localparam logic [CntW-1:0]   SplitLast   = 3'd3;
  localparam logic [CntW-1:0]   SortLast    = 3'd4;

  typedef logic [DigitW-1:0] digit_t;

  // Sequencer states, one-hot
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_EMIT  = 5'b00010,
    ST_SPLIT = 5'b00100,
    ST_SORT  = 5'b01000,
    ST_SUB   = 5'b10000
  } kap_state_e;

  // Compare-exchange pairs of the four-input sorting network
  function automatic logic [IdxW-1:0] sort_lo_idx(input logic [CntW-1:0] pass);
    case (pass)
      3'd0:    sort_lo_idx = 2'd0;
      3'd1:    sort_lo_idx = 2'd2;
      3'd2:    sort_lo_idx = 2'd0;
      3'd3:    sort_lo_idx = 2'd1;
      3'd4:    sort_lo_idx = 2'd1;
      default: sort_lo_idx = 2'd0;
    endcase
  endfunction

  function automatic logic [IdxW-1:0] sort_hi_idx(input logic [CntW-1:0] pass);
    case (pass)
      3'd0:    sort_hi_idx = 2'd1;
      3'd1:    sort_hi_idx = 2'd3;
      3'd2:    sort_hi_idx = 2'd2;
      3'd3:    sort_hi_idx = 2'd3;
      3'd4:    sort_hi_idx = 2'd2;
      default: sort_hi_idx = 2'd1;
    endcase
  endfunction

endpackage

// File: rtl/kaprekar_routine_4digit_core.sv
// Top level of the Kaprekar routine core: sequencer, digit registers, result register.
`timescale 1ns / 1ps
// Usage:
// - Slave stream s_axis takes one start value per item. The core then emits the
//   whole sequence on master stream m_axis: the start value at step 0, then the
//   value after each Kaprekar step, up to and including 6174 or the step limit.
// - m_axis_tlast marks the final item of a sequence; m_axis_tuser is set on it
//   when the final value is 6174, clear when the limit was reached instead.
// - cfg channel writes the 6-bit step limit (reset value 7). It is ready only
//   while the core is idle and the result register is empty.
// - Operation: the start value is loaded into the result register once the input
//   item is taken. Each further step splits the four digits on the shared
//   divide-by-ten unit, runs 5 passes of the shared compare-exchange unit,
//   forms the difference and loads the result register. s_axis_tready stays
//   low while a sequence is in progress.
// - A stalled receiver holds the result register; the sequencer computes the next
//   value and then waits in ST_EMIT until the item is taken; no result is lost.
// - Reset clears the sequencer and the result valid; the core comes up idle.
module kaprekar_routine_4digit_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Start value
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [kap_pkg::InDataW-1:0]    s_axis_tdata,   // [13:0] start_value
  // Sequence values
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [kap_pkg::OutDataW-1:0]   m_axis_tdata,   // [13:0] value, [19:14] step
  output logic                           m_axis_tlast,   // last
  output logic                           m_axis_tuser,   // [0] converged
  // Step limit register
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [kap_pkg::StepW-1:0]      cfg_data_i      // iteration_limit
);
  import kap_pkg::*;

  kap_state_e state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [StepW-1:0]  limit_q;
  logic [ValueW-1:0] cur_q, cur_d;
  logic [StepW-1:0]  step_q, step_d;
  logic [ValueW-1:0] work_q, work_d;
  digit_t            dig_q [NDigits];
  digit_t            dig_d [NDigits];

  logic              out_valid_q, out_valid_d;
  logic [ValueW-1:0] out_value_q;
  logic [StepW-1:0]  out_step_q;
  logic              out_last_q, out_conv_q;

  logic              hit, stop, out_load;
  logic [QuotW-1:0]  quot;
  digit_t            rem;
  digit_t            cs_a, cs_b, cs_lo, cs_hi;
  logic [IdxW-1:0]   lo_idx, hi_idx;
  digit_t            span_hi, span_mid;
  logic [ValueW-1:0] diff;

  // Shared units
  kap_div10 u_div10 (
    .num_i  (work_q),
    .quot_o (quot),
    .rem_o  (rem)
  );

  assign lo_idx = sort_lo_idx(cnt_q);
  assign hi_idx = sort_hi_idx(cnt_q);
  assign cs_a   = dig_q[lo_idx];
  assign cs_b   = dig_q[hi_idx];

  kap_cswap u_cswap (
    .a_i  (cs_a),
    .b_i  (cs_b),
    .lo_o (cs_lo),
    .hi_o (cs_hi)
  );

  // desc - asc with ascending digits d0..d3: 999*(d3-d0) + 90*(d2-d1)
  assign span_hi  = dig_q[3] - dig_q[0];
  assign span_mid = dig_q[2] - dig_q[1];
  assign diff     = ({10'd0, span_hi} * 14'd999) + ({10'd0, span_mid} * 14'd90);

  assign hit      = (cur_q == KapTarget);
  assign stop     = hit || (step_q >= limit_q);
  assign out_load = (state_q == ST_EMIT) && (!out_valid_q || m_axis_tready);

  // Sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cur_d   = cur_q;
    step_d  = step_q;
    work_d  = work_q;
    dig_d   = dig_q;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          cur_d   = s_axis_tdata[ValueW-1:0];
          step_d  = '0;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          if (stop) begin
            state_d = ST_IDLE;
          end else begin
            work_d  = cur_q;
            cnt_d   = '0;
            state_d = ST_SPLIT;
          end
        end
      end
      ST_SPLIT: begin
        dig_d[cnt_q[IdxW-1:0]] = rem;
        work_d = {{(ValueW-QuotW){1'b0}}, quot};
        if (cnt_q == SplitLast) begin
          cnt_d   = '0;
          state_d = ST_SORT;
        end else begin
          cnt_d = cnt_q + 3'd1;
        end
      end
      ST_SORT: begin
        dig_d[lo_idx] = cs_lo;
        dig_d[hi_idx] = cs_hi;
        if (cnt_q == SortLast) begin
          cnt_d   = '0;
          state_d = ST_SUB;
        end else begin
          cnt_d = cnt_q + 3'd1;
        end
      end
      ST_SUB: begin
        cur_d   = diff;
        step_d  = step_q + 6'd1;
        state_d = ST_EMIT;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      cur_q   <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      cur_q   <= cur_d;
      step_q  <= step_d;
    end
  end

  // Working registers, no reset needed
  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    dig_q  <= dig_d;
  end

  // Step limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      limit_q <= cfg_data_i;
    end
  end

  // Result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_value_q <= cur_q;
      out_step_q  <= step_q;
      out_last_q  <= stop;
      out_conv_q  <= hit;
    end
  end

  // Ports
  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = (state_q == ST_IDLE) && !out_valid_q;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW-ValueW-StepW){1'b0}}, out_step_q, out_value_q};
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_conv_q;

  // Checks
  a_conv_is_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tlast && out_value_q == KapTarget))
    else $error("converged result without target value");

  a_limit_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast && !m_axis_tuser) |-> (out_step_q == limit_q))
    else $error("non-converged end not at step limit");

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_step_q <= limit_q))
    else $error("step count beyond limit");

  a_diff_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SUB) |=> (cur_q < 14'd10000))
    else $error("step result out of four-digit range");

endmodule

// File: rtl/kap_div10.sv
// Divide-by-ten unit: quotient by reciprocal multiply, remainder as the low digit.
`timescale 1ns / 1ps
module kap_div10 (
  input  logic [kap_pkg::ValueW-1:0] num_i,
  output logic [kap_pkg::QuotW-1:0]  quot_o,
  output kap_pkg::digit_t            rem_o
);
  import kap_pkg::*;

  logic [ValueW+15:0] prod;
  logic [ValueW-1:0]  quot_x10;
  logic [ValueW-1:0]  rem_full;

  // Exact for all 14-bit operands
  assign prod   = {16'd0, num_i} * {{ValueW{1'b0}}, Recip10};
  assign quot_o = prod[RecipShift +: QuotW];

  // num - 10 * quot
  assign quot_x10 = {quot_o, 3'b000} + {2'b00, quot_o, 1'b0};
  assign rem_full = num_i - quot_x10;
  assign rem_o    = rem_full[DigitW-1:0];

endmodule

// File: rtl/kap_cswap.sv
// Compare-exchange unit shared by all passes of the digit sort.
`timescale 1ns / 1ps
module kap_cswap (
  input  kap_pkg::digit_t a_i,
  input  kap_pkg::digit_t b_i,
  output kap_pkg::digit_t lo_o,
  output kap_pkg::digit_t hi_o
);
  import kap_pkg::*;

  logic swap;

  assign swap = (a_i > b_i);
  assign lo_o = swap ? b_i : a_i;
  assign hi_o = swap ? a_i : b_i;

endmodule
